### design/rrts_pkg.sv
// Package for the round-robin task scheduler: sizes, slot states, operations,
// sequencer states. Used by the top level.
package rrts_pkg;
  localparam int unsigned MaxTasks   = 16;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned EventBits  = 64;
  localparam int unsigned TaskW      = $clog2(MaxTasks);
  localparam int unsigned QueueW     = $clog2(QueueDepth);
  localparam int unsigned StoreDepth = MaxTasks * QueueDepth;
  localparam int unsigned StoreW     = $clog2(StoreDepth);
  localparam int unsigned UsedW      = $clog2(MaxTasks + 1);
  localparam int unsigned StepW      = $clog2(MaxTasks + 1);

  typedef enum logic [1:0] {
    SlotUnused   = 2'd0,
    SlotReady    = 2'd1,
    SlotRunning  = 2'd2,
    SlotSleeping = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    OpCreate   = 3'd0,
    OpSleep    = 3'd1,
    OpSchedule = 3'd2,
    OpPush     = 3'd3,
    OpPop      = 3'd4
  } op_e;

  localparam logic [TaskW-1:0] IdleSlot = TaskW'(1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StWalk  = 5'b00010,
    StPick  = 5'b00100,
    StPopRd = 5'b01000,
    StOut   = 5'b10000
  } seq_state_e;
endpackage

### design/rrts_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module rrts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### design/round_robin_task_scheduler_top.sv
// Round-robin task scheduler top level.
// Depends on rrts_pkg and rrts_ram.
//
// Keeps a ring of task slots (state, 64-bit wake time, link) and one event
// ring per task held in a shared RAM. Each accepted word carries one
// operation and gives one result word. Create, push and unknown operations
// go straight to the result; pop first passes a RAM read state; sleep and
// schedule walk the ring with one shared 64-bit wake compare, one slot per
// cycle, then pass a pick state. The block takes no new word until the
// result has been taken. The event RAM needs no clearing: a pop only reads
// entries that a push wrote.
module round_robin_task_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [63:0] now_ticks_i,
  input  logic [63:0] sleep_ms_i,
  input  logic [3:0]  target_task_i,
  input  logic [63:0] event_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  current_task_o,
  output logic        ok_o,
  output logic [3:0]  created_id_o,
  output logic [63:0] event_out_o,
  output logic [31:0] push_total_o,
  output logic [31:0] pop_total_o,
  output logic [31:0] drop_total_o
);
  localparam int unsigned TW = rrts_pkg::TaskW;
  localparam int unsigned QW = rrts_pkg::QueueW;

  rrts_pkg::seq_state_e state_q;
  rrts_pkg::slot_state_e slot_q [rrts_pkg::MaxTasks];
  logic [63:0]   wake_q [rrts_pkg::MaxTasks];
  logic [TW-1:0] link_q [rrts_pkg::MaxTasks];
  logic [QW-1:0] head_q [rrts_pkg::MaxTasks];
  logic [QW-1:0] tail_q [rrts_pkg::MaxTasks];
  logic [TW-1:0] run_q, start_q, pick_q;
  logic [rrts_pkg::UsedW-1:0] used_q;
  logic [rrts_pkg::StepW-1:0] steps_q;
  logic [63:0] now_q;
  logic [31:0] push_q, pop_q, drop_q;

  // Result register.
  logic ok_q;
  logic [3:0] created_q;
  logic [63:0] ev_out_q;
  logic pop_ok_q;

  // RAM port.
  logic ram_we;
  logic [rrts_pkg::StoreW-1:0] ram_addr;
  logic [rrts_pkg::EventBits-1:0] ram_rdata;

  logic accept;
  assign in_stall_o  = (state_q != rrts_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == rrts_pkg::StOut);

  // Push decode, valid only when accepting.
  logic [TW-1:0] tgt;
  logic tgt_known, ring_full;
  logic [QW-1:0] tgt_head_nx;
  assign tgt         = TW'(target_task_i);
  assign tgt_known   = ({1'b0, target_task_i} < 5'(used_q));
  assign tgt_head_nx = head_q[tgt] + QW'(1);
  assign ring_full   = (tgt_head_nx == tail_q[tgt]);

  assign ram_we = accept && (operation_i == rrts_pkg::OpPush) && tgt_known && !ring_full;
  always_comb begin
    if (state_q == rrts_pkg::StIdle && operation_i == rrts_pkg::OpPush) begin
      ram_addr = {tgt, head_q[tgt]};
    end else begin
      ram_addr = {run_q, tail_q[run_q]};
    end
  end

  rrts_ram #(
    .Width(rrts_pkg::EventBits),
    .Depth(rrts_pkg::StoreDepth)
  ) u_event_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(event_in_i[rrts_pkg::EventBits-1:0]),
    .rdata_o(ram_rdata)
  );

  // Shared wake compare for the walk: this slot's time has come. In the pick
  // step the walk has stopped, so it also covers the start slot when home.
  logic wake_due;
  assign wake_due = (now_q >= wake_q[pick_q]);

  logic [TW-1:0] new_id;
  assign new_id = TW'(used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::StIdle;
      for (int i = 0; i < rrts_pkg::MaxTasks; i++) begin
        slot_q[i] <= rrts_pkg::SlotUnused;
        wake_q[i] <= '0;
        link_q[i] <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      slot_q[0] <= rrts_pkg::SlotRunning;
      slot_q[1] <= rrts_pkg::SlotReady;
      link_q[0] <= TW'(1);
      run_q     <= '0;
      start_q   <= '0;
      pick_q    <= '0;
      used_q    <= rrts_pkg::UsedW'(2);
      steps_q   <= '0;
      now_q     <= '0;
      push_q    <= '0;
      pop_q     <= '0;
      drop_q    <= '0;
      ok_q      <= 1'b0;
      created_q <= '0;
      ev_out_q  <= '0;
      pop_ok_q  <= 1'b0;
    end else begin
      unique case (state_q)
        rrts_pkg::StIdle: begin
          if (accept) begin
            ok_q      <= 1'b0;
            created_q <= '0;
            ev_out_q  <= '0;
            now_q     <= now_ticks_i;
            state_q   <= rrts_pkg::StOut;
            unique case (operation_i)
              rrts_pkg::OpCreate: begin
                if (used_q < rrts_pkg::UsedW'(rrts_pkg::MaxTasks)) begin
                  slot_q[new_id] <= rrts_pkg::SlotReady;
                  wake_q[new_id] <= '0;
                  head_q[new_id] <= '0;
                  tail_q[new_id] <= '0;
                  link_q[new_id] <= link_q[0];
                  link_q[0]      <= new_id;
                  used_q         <= used_q + rrts_pkg::UsedW'(1);
                  created_q      <= 4'(new_id);
                  ok_q           <= 1'b1;
                end
              end
              rrts_pkg::OpSleep, rrts_pkg::OpSchedule: begin
                if (operation_i == rrts_pkg::OpSleep) begin
                  wake_q[run_q] <= now_ticks_i + sleep_ms_i;
                  slot_q[run_q] <= rrts_pkg::SlotSleeping;
                end
                start_q <= run_q;
                pick_q  <= link_q[run_q];
                steps_q <= '0;
                ok_q    <= 1'b1;
                state_q <= rrts_pkg::StWalk;
              end
              rrts_pkg::OpPush: begin
                if (tgt_known) begin
                  if (ring_full) begin
                    drop_q <= drop_q + 32'd1;
                  end else begin
                    head_q[tgt] <= tgt_head_nx;
                    push_q      <= push_q + 32'd1;
                    if (slot_q[tgt] == rrts_pkg::SlotSleeping) begin
                      slot_q[tgt] <= rrts_pkg::SlotReady;
                    end
                    ok_q <= 1'b1;
                  end
                end
              end
              rrts_pkg::OpPop: begin
                pop_ok_q <= (head_q[run_q] != tail_q[run_q]);
                if (head_q[run_q] != tail_q[run_q]) begin
                  tail_q[run_q] <= tail_q[run_q] + QW'(1);
                  pop_q         <= pop_q + 32'd1;
                end
                state_q <= rrts_pkg::StPopRd;
              end
              default: ;
            endcase
          end
        end
        rrts_pkg::StWalk: begin
          // Visit one slot per cycle; wake it if due, stop on ready/running.
          if (pick_q == start_q ||
              steps_q >= rrts_pkg::StepW'(rrts_pkg::MaxTasks)) begin
            pick_q  <= start_q;
            state_q <= rrts_pkg::StPick;
          end else if (slot_q[pick_q] == rrts_pkg::SlotReady ||
                       slot_q[pick_q] == rrts_pkg::SlotRunning ||
                       (slot_q[pick_q] == rrts_pkg::SlotSleeping && wake_due)) begin
            state_q <= rrts_pkg::StPick;
          end else begin
            pick_q  <= link_q[pick_q];
            steps_q <= steps_q + rrts_pkg::StepW'(1);
          end
        end
        rrts_pkg::StPick: begin
          // Fall back to idle when the walk came home to a sleeper not yet due.
          if (pick_q == start_q && slot_q[start_q] == rrts_pkg::SlotSleeping &&
              !wake_due && start_q != rrts_pkg::IdleSlot) begin
            run_q <= rrts_pkg::IdleSlot;
            slot_q[rrts_pkg::IdleSlot] <= rrts_pkg::SlotRunning;
          end else begin
            run_q <= pick_q;
            slot_q[pick_q] <= rrts_pkg::SlotRunning;
          end
          state_q <= rrts_pkg::StOut;
        end
        rrts_pkg::StPopRd: begin
          if (pop_ok_q) begin
            ev_out_q <= 64'(ram_rdata);
            ok_q     <= 1'b1;
          end
          state_q <= rrts_pkg::StOut;
        end
        rrts_pkg::StOut: begin
          if (!out_stall_i) begin
            state_q <= rrts_pkg::StIdle;
          end
        end
        default: state_q <= rrts_pkg::StIdle;
      endcase
    end
  end

  assign current_task_o = 4'(run_q);
  assign ok_o           = ok_q;
  assign created_id_o   = created_q;
  assign event_out_o    = ev_out_q;
  assign push_total_o   = push_q;
  assign pop_total_o    = pop_q;
  assign drop_total_o   = drop_q;
endmodule
